// ===== design/ir_pulse_width_frame_encoder_unit_defines.svh =====
// Assertion macros shared by the frame encoder's checker.
`ifndef IR_PULSE_WIDTH_FRAME_ENCODER_UNIT_DEFINES_SVH
`define IR_PULSE_WIDTH_FRAME_ENCODER_UNIT_DEFINES_SVH

// Concurrent check on clk, muted while reset is asserted.
`define IRPWFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on clk that also holds during reset.
`define IRPWFE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/irpwfe_pkg.sv =====
// Shared types and constants of the pulse-width IR frame encoder.
package irpwfe_pkg;

    localparam int unsigned TickWidth  = 8;
    localparam int unsigned CmdWidth   = 24;
    localparam int unsigned ShiftWidth = 20;
    localparam int unsigned CountWidth = 5;
    localparam int unsigned CfgIdxWidth = 3;

    // Input opcodes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SEND   = 2'd1;
    localparam logic [1:0] OP_REPEAT = 2'd2;
    localparam logic [1:0] OP_STOP   = 2'd3;

    // Configuration register indexes
    localparam logic [CfgIdxWidth-1:0] CFG_HEADER_MARK = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_ONE_MARK    = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_ZERO_MARK   = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_SPACE       = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_GAP_COUNT   = 3'd4;

    // Configuration reset values
    localparam logic [TickWidth-1:0] HEADER_MARK_RST = 8'd96;
    localparam logic [TickWidth-1:0] ONE_MARK_RST    = 8'd48;
    localparam logic [TickWidth-1:0] ZERO_MARK_RST   = 8'd24;
    localparam logic [TickWidth-1:0] SPACE_RST       = 8'd24;
    localparam logic [TickWidth-1:0] GAP_COUNT_RST   = 8'd45;

    // Frame lengths in bits
    localparam logic [CountWidth-1:0] BITS_LONG  = 5'd20;
    localparam logic [CountWidth-1:0] BITS_MID   = 5'd15;
    localparam logic [CountWidth-1:0] BITS_SHORT = 5'd12;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HDR_MARK  = 3'd1,
        PH_HDR_SPACE = 3'd2,
        PH_BIT_MARK  = 3'd3,
        PH_BIT_SPACE = 3'd4,
        PH_GAP       = 3'd5
    } phase_t;

    typedef struct packed {
        logic [TickWidth-1:0] header_mark;
        logic [TickWidth-1:0] one_mark;
        logic [TickWidth-1:0] zero_mark;
        logic [TickWidth-1:0] space;
        logic [TickWidth-1:0] gap_count;
    } cfg_t;

    typedef struct packed {
        logic                 carrier_on;
        logic [TickWidth-1:0] segment_ticks;
        logic                 segment_valid;
        logic                 frame_started;
        logic                 busy_res;
    } result_t;

endpackage

// ===== design/ir_pulse_width_frame_encoder_unit.sv =====
// A word taken into the input register moves on to the result register when that register frees up.
// Throughput: one word per cycle unless the result register stalls; one frame-state pass per word.
// A stalled result register holds its word and backs up the input register, then in_ready.
// Reset (rst_n low, asynchronous): both stages empty, frame idle, stored command zero,
// bit counts twelve, timing registers at their power-on values.
module ir_pulse_width_frame_encoder_unit
    import irpwfe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input words
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             opcode,
    input  logic [CmdWidth-1:0]    command_word,
    // result words
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   carrier_on,
    output logic [TickWidth-1:0]   segment_ticks,
    output logic                   segment_valid,
    output logic                   frame_started,
    output logic                   busy_res,
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [TickWidth-1:0]   cfg_data
);

    // Input register stage
    logic                in_valid_reg,  in_valid_next;
    logic [1:0]          opcode_reg;
    logic [CmdWidth-1:0] command_reg;

    // Result register stage
    logic                out_valid_reg, out_valid_next;
    result_t             result_reg;

    result_t             core_result;
    cfg_t                cfg;
    logic                advance;
    logic                in_take;

    // Timing registers take a write on every cycle
    assign cfg_ready = 1'b1;

    irpwfe_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Advance the input word into the result register when that register frees up;
    // the frame state commits on the same edge.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    irpwfe_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .opcode       (opcode_reg),
        .command_word (command_reg),
        .cfg          (cfg),
        .result       (core_result)
    );

    always_comb
    begin
        in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    end

    always_comb
    begin
        out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: the input payload loads on a take, the result on an advance; both hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            opcode_reg  <= opcode;
            command_reg <= command_word;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign carrier_on    = result_reg.carrier_on;
    assign segment_ticks = result_reg.segment_ticks;
    assign segment_valid = result_reg.segment_valid;
    assign frame_started = result_reg.frame_started;
    assign busy_res      = result_reg.busy_res;

endmodule

// ===== design/irpwfe_cfg_regs.sv =====
// Configuration register file of the frame encoder.
module irpwfe_cfg_regs
    import irpwfe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CfgIdxWidth-1:0] wr_index,
    input  logic [TickWidth-1:0]   wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_HEADER_MARK: cfg_next.header_mark = wr_data;
                CFG_ONE_MARK:    cfg_next.one_mark    = wr_data;
                CFG_ZERO_MARK:   cfg_next.zero_mark   = wr_data;
                CFG_SPACE:       cfg_next.space       = wr_data;
                CFG_GAP_COUNT:   cfg_next.gap_count   = wr_data;
                default:         cfg_next = cfg_reg;  // drop writes past the map
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_mark <= HEADER_MARK_RST;
            cfg_reg.one_mark    <= ONE_MARK_RST;
            cfg_reg.zero_mark   <= ZERO_MARK_RST;
            cfg_reg.space       <= SPACE_RST;
            cfg_reg.gap_count   <= GAP_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/irpwfe_core.sv =====
// Frame sequencer: segment state machine, command store and result logic.
module irpwfe_core
    import irpwfe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [1:0]          opcode,
    input  logic [CmdWidth-1:0] command_word,
    input  cfg_t                cfg,
    output result_t             result
);

    phase_t                  phase_reg,        phase_next;
    logic [ShiftWidth-1:0]   shift_word_reg,   shift_word_next;
    logic [CountWidth-1:0]   bits_sent_reg,    bits_sent_next;
    logic [CountWidth-1:0]   frame_bits_reg,   frame_bits_next;
    logic [TickWidth-1:0]    gap_counter_reg,  gap_counter_next;
    logic [CmdWidth-1:0]     stored_cmd_reg,   stored_cmd_next;
    logic [CountWidth-1:0]   stored_bits_reg,  stored_bits_next;

    logic [CountWidth-1:0]   send_bits;
    logic [CountWidth-1:0]   bits_inc;
    logic [TickWidth-1:0]    gap_inc;
    logic                    start_ok;

    // Bit count chosen by a send word
    always_comb
    begin
        if (command_word[23])
            send_bits = BITS_LONG;
        else if (command_word[15])
            send_bits = BITS_MID;
        else
            send_bits = BITS_SHORT;
    end

    assign bits_inc = bits_sent_reg + 5'd1;
    assign gap_inc  = (gap_counter_reg != 8'hFF) ? gap_counter_reg + 8'd1 : gap_counter_reg;

    // A frame starts only from idle, with a nonzero command after this word's store
    always_comb
    begin
        case (opcode)
            OP_SEND:   start_ok = (phase_reg == PH_IDLE) && (command_word != '0);
            OP_REPEAT: start_ok = (phase_reg == PH_IDLE) && (stored_cmd_reg != '0);
            default:   start_ok = 1'b0;
        endcase
    end

    // Next state
    always_comb
    begin
        phase_next       = phase_reg;
        shift_word_next  = shift_word_reg;
        bits_sent_next   = bits_sent_reg;
        frame_bits_next  = frame_bits_reg;
        gap_counter_next = gap_counter_reg;
        stored_cmd_next  = stored_cmd_reg;
        stored_bits_next = stored_bits_reg;
        if (step)
        begin
            if (opcode == OP_TICK)
            begin
                unique case (phase_reg)
                    PH_HDR_MARK:  phase_next = PH_HDR_SPACE;
                    PH_HDR_SPACE: phase_next = PH_BIT_MARK;
                    PH_BIT_MARK:
                    begin
                        shift_word_next = {1'b0, shift_word_reg[ShiftWidth-1:1]};
                        phase_next      = PH_BIT_SPACE;
                    end
                    PH_BIT_SPACE:
                    begin
                        bits_sent_next = bits_inc;
                        phase_next     = (bits_inc == frame_bits_reg) ? PH_GAP : PH_BIT_MARK;
                    end
                    PH_GAP:
                    begin
                        if (gap_inc >= cfg.gap_count)
                        begin
                            bits_sent_next   = '0;
                            gap_counter_next = '0;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            gap_counter_next = gap_inc;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
            else if (opcode == OP_STOP)
            begin
                stored_cmd_next = '0;
            end
            else
            begin
                if (opcode == OP_SEND)
                begin
                    stored_cmd_next  = command_word;
                    stored_bits_next = send_bits;
                end
                if (start_ok)
                begin
                    shift_word_next  = stored_cmd_next[ShiftWidth-1:0];
                    frame_bits_next  = stored_bits_next;
                    bits_sent_next   = '0;
                    gap_counter_next = '0;
                    phase_next       = PH_HDR_MARK;
                end
            end
        end
    end

    // Result word
    always_comb
    begin
        result = '0;
        if (opcode == OP_TICK)
        begin
            unique case (phase_reg)
                PH_HDR_MARK:
                begin
                    result.carrier_on    = 1'b1;
                    result.segment_ticks = cfg.header_mark;
                    result.segment_valid = 1'b1;
                end
                PH_BIT_MARK:
                begin
                    result.carrier_on    = 1'b1;
                    result.segment_ticks = shift_word_reg[0] ? cfg.one_mark : cfg.zero_mark;
                    result.segment_valid = 1'b1;
                end
                PH_HDR_SPACE, PH_BIT_SPACE, PH_GAP:
                begin
                    result.segment_ticks = cfg.space;
                    result.segment_valid = 1'b1;
                end
                default: result.segment_valid = 1'b0;
            endcase
        end
        result.frame_started = start_ok;
        result.busy_res      = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            shift_word_reg  <= '0;
            bits_sent_reg   <= '0;
            frame_bits_reg  <= BITS_SHORT;
            gap_counter_reg <= '0;
            stored_cmd_reg  <= '0;
            stored_bits_reg <= BITS_SHORT;
        end
        else
        begin
            phase_reg       <= phase_next;
            shift_word_reg  <= shift_word_next;
            bits_sent_reg   <= bits_sent_next;
            frame_bits_reg  <= frame_bits_next;
            gap_counter_reg <= gap_counter_next;
            stored_cmd_reg  <= stored_cmd_next;
            stored_bits_reg <= stored_bits_next;
        end
    end

endmodule

// ===== design/irpwfe_checker.sv =====
// Port-level checker for the frame encoder, bound to the top level.
`include "ir_pulse_width_frame_encoder_unit_defines.svh"

module irpwfe_checker
    import irpwfe_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic                   carrier_on,
    input logic [TickWidth-1:0]   segment_ticks,
    input logic                   segment_valid,
    input logic                   frame_started,
    input logic                   busy_res
);

    `IRPWFE_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid, "result word valid during reset")

    `IRPWFE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable({carrier_on,
        segment_ticks, segment_valid, frame_started, busy_res}), "stalled result word changed")

    `IRPWFE_ASSERT(a_start_busy, out_valid && frame_started |->
        busy_res && !segment_valid, "frame start without busy or with a segment")

    `IRPWFE_ASSERT(a_no_segment, out_valid && !segment_valid |->
        !carrier_on && (segment_ticks == '0), "carrier or length without a segment")

    `IRPWFE_ASSERT(a_started_follows_idle, out_valid && out_ready && !busy_res ##1
        out_valid && segment_valid |-> 1'b0, "segment given after the frame went idle")

endmodule

bind ir_pulse_width_frame_encoder_unit irpwfe_checker u_irpwfe_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the pulse-width IR frame encoder unit.
`timescale 1ns / 1ps

module testbench;
    import irpwfe_pkg::*;

    // A stall of this many cycles with no word moving on any channel ends the run.
    localparam int QUIET_LIMIT = 2000;
    // Rough number of random words queued under each timing setting.
    localparam int PHASE_WORDS = 280;

    typedef struct packed {
        logic [1:0]          op;
        logic [CmdWidth-1:0] cmd;
    } enc_word_t;

    // ------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                   clk          = 1'b0;
    logic                   rst_n;
    logic                   in_valid     = 1'b0;
    logic [1:0]             opcode       = OP_TICK;
    logic [CmdWidth-1:0]    command_word = '0;
    logic                   out_ready    = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic [CfgIdxWidth-1:0] cfg_index    = CFG_HEADER_MARK;
    logic [TickWidth-1:0]   cfg_data     = '0;

    logic                   in_ready;
    logic                   out_valid;
    logic                   carrier_on;
    logic [TickWidth-1:0]   segment_ticks;
    logic                   segment_valid;
    logic                   frame_started;
    logic                   busy_res;
    logic                   cfg_ready;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    ir_pulse_width_frame_encoder_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .command_word  (command_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .carrier_on    (carrier_on),
        .segment_ticks (segment_ticks),
        .segment_valid (segment_valid),
        .frame_started (frame_started),
        .busy_res      (busy_res),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Queues, counters and idle rates
    // ------------------------------------------------------------------
    enc_word_t queued_words[$];        // words waiting for the driver
    result_t   expected_segments[$];   // predicted result words, oldest first

    int words_accepted   = 0;
    int segments_checked = 0;
    int frames_begun     = 0;
    int reg_writes       = 0;
    int mismatches       = 0;
    int quiet_cycles     = 0;
    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;

    // ------------------------------------------------------------------
    // Frame encoder prediction: timing registers and frame state
    // ------------------------------------------------------------------
    cfg_t                  timing = {HEADER_MARK_RST, ONE_MARK_RST, ZERO_MARK_RST,
                                     SPACE_RST, GAP_COUNT_RST};
    phase_t                frame_phase    = PH_IDLE;
    logic [ShiftWidth-1:0] bit_shift      = '0;
    logic [CountWidth-1:0] bits_done      = '0;
    logic [CountWidth-1:0] frame_len      = BITS_SHORT;
    logic [TickWidth-1:0]  gap_seen       = '0;
    logic [CmdWidth-1:0]   held_command   = '0;
    logic [CountWidth-1:0] held_len       = BITS_SHORT;

    // Start a frame from the held command; only when idle and something is held.
    // The bit count is latched here and kept for the whole frame.
    function automatic logic launch_frame();
        if (held_command == '0 || frame_phase != PH_IDLE)
            return 1'b0;
        bit_shift   = held_command[ShiftWidth-1:0];
        frame_len   = held_len;
        bits_done   = '0;
        gap_seen    = '0;
        frame_phase = PH_HDR_MARK;
        return 1'b1;
    endfunction

    // Advance the frame state by one input word and return the result word it causes.
    function automatic result_t encode_step(input logic [1:0] op,
                                            input logic [CmdWidth-1:0] cmd);
        result_t r;
        r = '0;
        case (op)
            OP_TICK:
            begin
                case (frame_phase)
                    PH_HDR_MARK:
                    begin
                        r.carrier_on    = 1'b1;
                        r.segment_ticks = timing.header_mark;
                        r.segment_valid = 1'b1;
                        frame_phase     = PH_HDR_SPACE;
                    end
                    PH_HDR_SPACE:
                    begin
                        r.segment_ticks = timing.space;
                        r.segment_valid = 1'b1;
                        frame_phase     = PH_BIT_MARK;
                    end
                    PH_BIT_MARK:
                    begin
                        // LSB first: a one gets the one-mark length
                        r.carrier_on    = 1'b1;
                        r.segment_valid = 1'b1;
                        r.segment_ticks = bit_shift[0] ? timing.one_mark : timing.zero_mark;
                        bit_shift       = bit_shift >> 1;
                        frame_phase     = PH_BIT_SPACE;
                    end
                    PH_BIT_SPACE:
                    begin
                        r.segment_ticks = timing.space;
                        r.segment_valid = 1'b1;
                        bits_done       = bits_done + 5'd1;
                        frame_phase     = (bits_done == frame_len) ? PH_GAP : PH_BIT_MARK;
                    end
                    PH_GAP:
                    begin
                        // Saturating gap count; a gap count of zero still gives one segment
                        r.segment_ticks = timing.space;
                        r.segment_valid = 1'b1;
                        if (gap_seen != 8'hFF)
                            gap_seen = gap_seen + 8'd1;
                        if (gap_seen >= timing.gap_count)
                        begin
                            bits_done   = '0;
                            gap_seen    = '0;
                            frame_phase = PH_IDLE;
                        end
                    end
                    default:
                        frame_phase = PH_IDLE;
                endcase
            end
            OP_SEND:
            begin
                held_command = cmd;
                if (cmd[23])
                    held_len = BITS_LONG;
                else if (cmd[15])
                    held_len = BITS_MID;
                else
                    held_len = BITS_SHORT;
                r.frame_started = launch_frame();
            end
            OP_REPEAT:
                r.frame_started = launch_frame();
            OP_STOP:
                held_command = '0;
        endcase
        r.busy_res = (frame_phase != PH_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued words, predict each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_words
        logic      advance;
        enc_word_t w;
        result_t   predicted;
        if (rst_n)
        begin
            advance = !in_valid;
            if (in_valid && in_ready)
            begin
                predicted = encode_step(opcode, command_word);
                expected_segments.push_back(predicted);
                if (predicted.frame_started)
                    frames_begun++;
                words_accepted++;
                advance = 1'b1;
            end
            // Hold the current word until it is taken; only then pick the next one
            if (advance)
            begin
                if (queued_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    w = queued_words.pop_front();
                    in_valid     <= 1'b1;
                    opcode       <= w.op;
                    command_word <= w.cmd;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare every result word with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_segments
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.carrier_on    = carrier_on;
                got.segment_ticks = segment_ticks;
                got.segment_valid = segment_valid;
                got.frame_started = frame_started;
                got.busy_res      = busy_res;
                if (expected_segments.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: result word with nothing expected: ",
                                  "carrier %0b ticks %0d valid %0b start %0b busy %0b"},
                                 $realtime, got.carrier_on, got.segment_ticks,
                                 got.segment_valid, got.frame_started, got.busy_res);
                end
                else
                begin
                    want = expected_segments.pop_front();
                    if (got.carrier_on !== want.carrier_on
                        || got.segment_ticks !== want.segment_ticks
                        || got.segment_valid !== want.segment_valid
                        || got.frame_started !== want.frame_started
                        || got.busy_res !== want.busy_res)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result word %0d differs", $realtime, segments_checked);
                            $display("  expected carrier %0b ticks %0d valid %0b start %0b busy %0b",
                                     want.carrier_on, want.segment_ticks, want.segment_valid,
                                     want.frame_started, want.busy_res);
                            $display("  actual   carrier %0b ticks %0d valid %0b start %0b busy %0b",
                                     got.carrier_on, got.segment_ticks, got.segment_valid,
                                     got.frame_started, got.busy_res);
                        end
                    end
                end
                segments_checked++;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles in which no word moves on any channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("stalled: no word moved for %0d cycles, %0d results still expected",
                 QUIET_LIMIT, expected_segments.size());
        $display("testbench: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_word(input logic [1:0] op, input logic [CmdWidth-1:0] cmd);
        queued_words.push_back({op, cmd});
    endtask

    // Ticks carry random command bits, which the block must ignore.
    task automatic push_ticks(input int count);
        for (int i = 0; i < count; i++)
            push_word(OP_TICK, CmdWidth'($urandom));
    endtask

    // Stop feeding until every queued word is taken and every result is back.
    task automatic drain_wait();
        do
            @(posedge clk);
        while (queued_words.size() != 0 || in_valid || expected_segments.size() != 0);
    endtask

    // Write one timing register; update the predicted copy when the write is taken.
    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                             input logic [TickWidth-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_HEADER_MARK: timing.header_mark = val;
            CFG_ONE_MARK:    timing.one_mark    = val;
            CFG_ZERO_MARK:   timing.zero_mark   = val;
            CFG_SPACE:       timing.space       = val;
            CFG_GAP_COUNT:   timing.gap_count   = val;
            default:         ;
        endcase
        reg_writes++;
    endtask

    // Queue one frame: a send (or a repeat) with random content, then enough ticks
    // to run it out, with stray commands mixed in and now and then a cut-short run.
    int gen_len = 12;

    task automatic queue_frame(input logic [TickWidth-1:0] gap, output int n);
        logic [CmdWidth-1:0] cmd;
        logic [1:0]          noise_op;
        int                  ticks;
        n   = 0;
        cmd = CmdWidth'($urandom);
        case ($urandom_range(2))
            0: cmd[23] = 1'b1;
            1: begin cmd[23] = 1'b0; cmd[15] = 1'b1; end
            default: begin cmd[23] = 1'b0; cmd[15] = 1'b0; end
        endcase
        if ($urandom_range(30) == 0)
            cmd = '0;
        if ($urandom_range(4) == 0)
        begin
            push_word(OP_REPEAT, CmdWidth'($urandom));
        end
        else
        begin
            push_word(OP_SEND, cmd);
            gen_len = cmd[23] ? 20 : (cmd[15] ? 15 : 12);
        end
        n++;
        ticks = 2 + 2 * gen_len + ((gap == 0) ? 1 : gap) + $urandom_range(2);
        if ($urandom_range(9) == 0)
            ticks = $urandom_range(ticks);
        for (int i = 0; i < ticks; i++)
        begin
            if ($urandom_range(11) == 0)
            begin
                noise_op = 2'($urandom_range(OP_SEND, OP_STOP));
                push_word(noise_op, CmdWidth'($urandom));
                n++;
            end
            push_word(OP_TICK, CmdWidth'($urandom));
            n++;
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : run
        logic [TickWidth-1:0] setting [5];
        int                   placed;
        int                   n;

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the power-on timing: sender idles lightly,
        // receiver stalls heavily.
        send_idle_pct = 18;
        recv_idle_pct = 76;
        push_word(OP_TICK, 24'h000000);      // tick with no frame running
        push_word(OP_REPEAT, 24'hFFFFFF);    // repeat with nothing stored
        push_word(OP_SEND, 24'h000000);      // zero command never starts a frame
        push_word(OP_STOP, 24'hFFFFFF);      // stop while idle
        push_word(OP_SEND, 24'h7F7A5B);      // twelve-bit frame starts
        push_ticks(1);                       // header mark
        push_word(OP_SEND, 24'h80FFFF);      // send while busy: held, no start
        push_ticks(1);                       // header space
        push_word(OP_REPEAT, 24'h000000);    // repeat while busy
        push_ticks(3);
        push_word(OP_STOP, 24'h000000);      // stop mid-frame: frame runs on
        push_ticks(21 + 5);                  // remaining bits, then five gap segments
        drain_wait();
        // Lower the gap count below what the running gap has already reached
        write_reg(CFG_GAP_COUNT, 8'd3);
        push_ticks(2);                       // gap ends at once, then an idle tick
        push_word(OP_REPEAT, 24'h000000);    // held command was cleared by stop
        push_word(OP_SEND, 24'hFFFFFF);      // twenty-bit frame from the widest word
        push_word(OP_STOP, 24'h000000);

        // Random part: six timing settings, extremes among them
        for (int ph = 0; ph < 6; ph++)
        begin
            drain_wait();
            case (ph)
                0: setting = '{HEADER_MARK_RST, ONE_MARK_RST, ZERO_MARK_RST,
                               SPACE_RST, GAP_COUNT_RST};
                1: setting = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
                2: setting = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
                default:
                begin
                    for (int i = 0; i < 4; i++)
                        setting[i] = TickWidth'($urandom);
                    setting[4] = TickWidth'($urandom_range(ph == 3 ? 8 : (ph == 4 ? 20 : 60)));
                end
            endcase
            write_reg(CFG_HEADER_MARK, setting[0]);
            write_reg(CFG_ONE_MARK,    setting[1]);
            write_reg(CFG_ZERO_MARK,   setting[2]);
            write_reg(CFG_SPACE,       setting[3]);
            write_reg(CFG_GAP_COUNT,   setting[4]);

            // Swap idle rates after the first third, drop idling for the last
            if (ph < 2)
            begin
                send_idle_pct = 18;
                recv_idle_pct = 76;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 18;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            placed = 0;
            while (placed < PHASE_WORDS)
            begin
                queue_frame(setting[4], n);
                placed += n;
                // Now and then hold off until every result is back
                if ($urandom_range(9) == 0)
                    drain_wait();
            end
        end

        // Let the pipeline settle so that any stray result word shows up
        drain_wait();
        repeat (8) @(posedge clk);

        $display("covered %0d input words, %0d frames started, %0d result words checked",
                 words_accepted, frames_begun, segments_checked);
        $display("under %0d register writes; %0d mismatches, %0d results never arrived",
                 reg_writes, mismatches, expected_segments.size());
        if (mismatches == 0 && expected_segments.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
